/* rtl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the FIFO burst accelerometer averager
// Field widths, packing positions and the default burst length.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int LEFT_W          = 7;
  localparam int USED_W          = 6;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_W          = $clog2(NUM_AXES);
  localparam int MAX_SAMPLES_DEF = 32;

  // Input beat: x, y, z, entries_left from bit 0 up, zero filled to bytes.
  localparam int IN_BITS   = NUM_AXES * SAMPLE_W + LEFT_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output beat: avg x, y, z, samples_used from bit 0 up, zero filled to bytes.
  localparam int OUT_BITS   = NUM_AXES * SAMPLE_W + USED_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* rtl/fba_div.sv */
// ----------------------------------------------------------------------------
// fba_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fba_div #(
  parameter int DW = 22,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int SW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy;
  logic [SW-1:0] step;
  logic [DW-1:0] dvd;
  logic [VW-1:0] rem;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem, dvd[DW-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // The dividend register shifts out its top bit each cycle and takes the
  // new quotient bit at the bottom, so it holds the quotient at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dvd  <= {dvd[DW-2:0], fits};
        rem  <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        step <= step + 1'b1;
        if (step == SW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

/* rtl/fifo_burst_accel_averager.sv */
// ----------------------------------------------------------------------------
// fifo_burst_accel_averager: three-axis accelerometer FIFO burst averager
// Sums FIFO reads per axis and divides by the read count at burst end
// through one shared iterative divider; passes reads through in direct mode.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  s_*      in         tdata: sample_x, sample_y, sample_z, entries_left;
//                      tuser: bus_ok
//  m_*      out        tdata: avg_x, avg_y, avg_z, samples_used;
//                      tuser: read_failed
//  cfg_*    in         cfg_data: use_fifo (taken only while the sequencer idles)
//
// A read that does not end a burst goes from S_IDLE to S_PROC and back; a
// direct or failed read goes on through S_PUT. A burst end runs the divider
// once per axis, through S_DSTART and S_DWAIT each time, and then S_PUT.
// Synchronous reset clears mode, sums and count; no clearing pass.
// While a result waits on m_tready the next beat is still taken and worked
// on until it needs the output register.
// ----------------------------------------------------------------------------
module fifo_burst_accel_averager #(
  parameter int MAX_SAMPLES = fba_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z, [54:48] entries_left
  input  logic [fba_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] bus_ok
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] avg_x, [31:16] avg_y, [47:32] avg_z, [53:48] samples_used
  output logic [fba_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] read_failed
  output logic                           m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = fba_pkg::SAMPLE_W + CNT_W;
  localparam int SW    = fba_pkg::SAMPLE_W;
  localparam int AW    = fba_pkg::AXIS_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PROC   = 5'b00010,
    S_DSTART = 5'b00100,
    S_DWAIT  = 5'b01000,
    S_PUT    = 5'b10000
  } state_t;

  state_t                    state;
  logic                      use_fifo;
  logic [CNT_W-1:0]          cnt;
  logic [AW-1:0]             axis;
  logic signed [SUM_W-1:0]   sum_r [fba_pkg::NUM_AXES];

  logic [fba_pkg::IN_DATA_W-1:0] in_data;
  logic                          in_ok;
  logic signed [SW-1:0]          res_avg [fba_pkg::NUM_AXES];
  logic [fba_pkg::USED_W-1:0]    res_used;
  logic                          res_fail;

  logic [CNT_W-1:0]         cnt_inc;
  logic                     burst_end;
  logic signed [SW-1:0]     smp [fba_pkg::NUM_AXES];
  logic [fba_pkg::LEFT_W-1:0] left;
  logic signed [SUM_W-1:0]  cur_sum;
  logic                     cur_neg;
  logic [SUM_W-1:0]         cur_mag;
  logic                     div_start;
  logic                     div_done;
  logic [SUM_W-1:0]         div_q;
  logic [SUM_W-1:0]         q_signed;
  logic                     out_free;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
      smp[a] = in_data[a*SW +: SW];
    end
  end

  assign left      = in_data[fba_pkg::NUM_AXES*SW +: fba_pkg::LEFT_W];
  assign cnt_inc   = cnt + 1'b1;
  assign burst_end = (cnt_inc >= CNT_W'(MAX_SAMPLES)) || (left == '0);

  // Divider works on magnitudes; the sign goes back on the quotient.
  assign cur_sum   = sum_r[axis];
  assign cur_neg   = cur_sum[SUM_W-1];
  assign cur_mag   = cur_neg ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
  assign div_start = (state == S_DSTART);
  assign q_signed  = cur_neg ? (~div_q + 1'b1) : div_q;

  fba_div #(
    .DW(SUM_W),
    .VW(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_mag),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      use_fifo <= 1'b0;
      cnt      <= '0;
      axis     <= '0;
      m_tvalid <= 1'b0;
      for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != S_PUT) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        use_fifo <= cfg_data;
        cnt      <= '0;
        for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
          sum_r[a] <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_data <= s_tdata;
            in_ok   <= s_tuser;
            state   <= S_PROC;
          end
        end
        S_PROC: begin
          if (!in_ok) begin
            cnt <= '0;
            for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
              sum_r[a]   <= '0;
              res_avg[a] <= '0;
            end
            res_used <= '0;
            res_fail <= 1'b1;
            state    <= S_PUT;
          end else if (!use_fifo) begin
            for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
              res_avg[a] <= smp[a];
            end
            res_used <= '0;
            res_fail <= 1'b0;
            state    <= S_PUT;
          end else begin
            cnt <= cnt_inc;
            for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
              sum_r[a] <= sum_r[a] + SUM_W'(smp[a]);
            end
            if (burst_end) begin
              res_used <= fba_pkg::USED_W'(cnt_inc);
              res_fail <= 1'b0;
              axis     <= '0;
              state    <= S_DSTART;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            res_avg[axis] <= q_signed[SW-1:0];
            if (axis == AW'(fba_pkg::NUM_AXES - 1)) begin
              cnt <= '0;
              for (int a = 0; a < fba_pkg::NUM_AXES; a++) begin
                sum_r[a] <= '0;
              end
              state <= S_PUT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_DSTART;
            end
          end
        end
        S_PUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= fba_pkg::OUT_DATA_W'({res_used, res_avg[2], res_avg[1], res_avg[0]});
            m_tuser  <= res_fail;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A failure beat carries all-zero averages and count.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("failure result carries nonzero data");

  // Direct mode never holds a partial burst.
  a_direct_empty: assert property (@(posedge clk) disable iff (rst)
    (!use_fifo && state == S_IDLE) |-> (cnt == '0))
    else $error("read count nonzero in direct mode");

  // Between items the count stays below the burst length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt < CNT_W'(MAX_SAMPLES)))
    else $error("read count reached burst length while idle");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DWAIT))
    else $error("divider finished outside its wait state");

  // With a burst length below 64, a burst result always reports a nonzero count.
  a_used_nonzero: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && !m_tuser && use_fifo && MAX_SAMPLES < 64)
      |-> (m_tdata[fba_pkg::NUM_AXES*SW +: fba_pkg::USED_W] != '0))
    else $error("burst result with zero sample count");

endmodule

/* tb/sv/fifo_burst_accel_averager_tb.sv */
// ----------------------------------------------------------------------------
// fifo_burst_accel_averager_tb: self-checking bench for the burst averager
// Drives accelerometer FIFO reads in direct and FIFO mode with random gaps and
// output stalls, predicts every result and checks each output beat in order.
// ----------------------------------------------------------------------------
module fifo_burst_accel_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BURST_MAX   = fba_pkg::MAX_SAMPLES_DEF;
  localparam int REPORT_MAX  = 10;
  localparam int SETTLE_CYC  = 100;
  localparam int RANDOM_READS = 1300;

  typedef struct {
    logic [fba_pkg::SAMPLE_W-1:0] ax;
    logic [fba_pkg::SAMPLE_W-1:0] ay;
    logic [fba_pkg::SAMPLE_W-1:0] az;
    logic [fba_pkg::USED_W-1:0]   used;
    logic                         failed;
  } avg_beat_t;

  class burst_avg_scoreboard;
    avg_beat_t avg_q[$];
    bit        fifo_mode;
    int        sum_x, sum_y, sum_z;
    int        reads;
    int        errors;

    function void clear_burst();
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      reads = 0;
    endfunction

    // Any mode write throws away a partial burst.
    function void set_mode(bit m);
      fifo_mode = m;
      clear_burst();
    endfunction

    function void note_read(logic signed [fba_pkg::SAMPLE_W-1:0] x,
                            logic signed [fba_pkg::SAMPLE_W-1:0] y,
                            logic signed [fba_pkg::SAMPLE_W-1:0] z,
                            logic [fba_pkg::LEFT_W-1:0] left,
                            logic ok);
      avg_beat_t b;
      b.ax = '0;
      b.ay = '0;
      b.az = '0;
      b.used = '0;
      b.failed = 1'b0;
      if (!ok) begin
        clear_burst();
        b.failed = 1'b1;
        avg_q.push_back(b);
      end else if (!fifo_mode) begin
        b.ax = x;
        b.ay = y;
        b.az = z;
        avg_q.push_back(b);
      end else begin
        reads++;
        sum_x += int'(x);
        sum_y += int'(y);
        sum_z += int'(z);
        if (reads >= BURST_MAX || left == 0) begin
          // Integer division in SystemVerilog truncates toward zero.
          b.ax = fba_pkg::SAMPLE_W'(sum_x / reads);
          b.ay = fba_pkg::SAMPLE_W'(sum_y / reads);
          b.az = fba_pkg::SAMPLE_W'(sum_z / reads);
          b.used = fba_pkg::USED_W'(reads);
          avg_q.push_back(b);
          clear_burst();
        end
      end
    endfunction

    function void check_beat(avg_beat_t got);
      avg_beat_t want;
      if (avg_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected beat: x=%h y=%h z=%h used=%0d failed=%b",
                   got.ax, got.ay, got.az, got.used, got.failed);
        return;
      end
      want = avg_q.pop_front();
      if (got.ax !== want.ax || got.ay !== want.ay || got.az !== want.az ||
          got.used !== want.used || got.failed !== want.failed) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected x=%h y=%h z=%h used=%0d failed=%b,",
                   want.ax, want.ay, want.az, want.used, want.failed,
                   " got x=%h y=%h z=%h used=%0d failed=%b",
                   got.ax, got.ay, got.az, got.used, got.failed);
      end
    endfunction

    function int pending();
      return avg_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [fba_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [fba_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic                           cfg_data = 1'b0;

  burst_avg_scoreboard sb = new();
  int  reads_sent = 0;
  bit  no_stall = 1'b0;

  fifo_burst_accel_averager u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("fifo_burst_accel_averager_tb NOT OK");
    $finish;
  end

  // Everything is sampled at the edge, before any register of the edge updates.
  always @(posedge clk) begin
    avg_beat_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.ax = m_tdata[15:0];
        got.ay = m_tdata[31:16];
        got.az = m_tdata[47:32];
        got.used = m_tdata[53:48];
        got.failed = m_tuser;
        sb.check_beat(got);
      end
      if (cfg_valid && cfg_ready)
        sb.set_mode(cfg_data);
      if (s_tvalid && s_tready)
        sb.note_read(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                     s_tdata[54:48], s_tuser);
    end
  end

  // Result side: a fresh random stall, which may be zero, before every beat.
  initial begin
    int unsigned stall;
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_read(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                           input logic [6:0] left, input logic ok);
    int unsigned gap;
    logic [fba_pkg::IN_DATA_W-1:0] beat;
    gap = no_stall ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat = '0;
    beat[15:0]  = x;
    beat[31:16] = y;
    beat[47:32] = z;
    beat[54:48] = left;
    s_tdata  <= beat;
    s_tuser  <= ok;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    reads_sent++;
  endtask

  // Sender holds off until every result is out, then lets the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A burst of reads, one failed if inject_fail is set; the last reports an empty FIFO.
  // Bursts longer than the maximum are cut by the block itself.
  task automatic send_burst(input int len, input bit extreme, input bit inject_fail);
    int fail_at;
    logic [15:0] ex, ey, ez, x, y, z;
    logic [6:0] left;
    fail_at = inject_fail ? $urandom_range(0, len - 1) : -1;
    ex = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    ey = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    ez = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    for (int i = 0; i < len; i++) begin
      x = extreme ? ex : 16'($urandom);
      y = extreme ? ey : 16'($urandom);
      z = extreme ? ez : 16'($urandom);
      left = (i == len - 1) ? 7'd0 : 7'($urandom_range(1, 127));
      send_read(x, y, z, left, i != fail_at);
    end
  endtask

  initial begin
    bit mode;
    int phase_end;
    int kind;
    int len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Direct mode out of reset: extremes pass through, failures zero the fields.
    send_read(16'h7FFF, 16'h8000, 16'h0000, 7'd0, 1'b1);
    send_read(16'h8000, 16'h7FFF, 16'hFFFF, 7'd127, 1'b1);
    send_read(16'h1234, 16'h8000, 16'h7FFF, 7'd5, 1'b0);

    write_mode(1'b1);
    // Single-read burst at the negative extreme.
    send_read(16'h8000, 16'h8000, 16'h8000, 7'd0, 1'b1);
    // Three reads whose averages truncate toward zero on both signs.
    send_read(16'hFFFF, 16'hFFFB, 16'd7, 7'd2, 1'b1);
    send_read(16'hFFFF, 16'h0000, 16'd7, 7'd1, 1'b1);
    send_read(16'h0001, 16'h0000, 16'd8, 7'd0, 1'b1);
    // A bus failure in the middle of a burst discards it.
    send_read(16'd100, 16'd200, 16'd300, 7'd5, 1'b1);
    send_read(16'd1, 16'd2, 16'd3, 7'd4, 1'b0);
    send_read(16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd127, 1'b1);
    send_read(16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd0, 1'b1);

    write_mode(1'b0);
    send_read(16'h0000, 16'hFFFF, 16'h8000, 7'd64, 1'b1);
    send_read(16'h5555, 16'hAAAA, 16'h0F0F, 7'd0, 1'b0);

    // A mode write drops the reads taken so far, even when the mode stays.
    write_mode(1'b1);
    send_read(16'd1000, 16'd1000, 16'd1000, 7'd3, 1'b1);
    send_read(16'd2000, 16'd2000, 16'd2000, 7'd2, 1'b1);
    write_mode(1'b1);
    send_read(16'hFFF6, 16'd10, 16'd0, 7'd0, 1'b1);

    while (reads_sent < RANDOM_READS) begin
      mode = ($urandom_range(0, 3) != 0);
      write_mode(mode);
      no_stall = ($urandom_range(0, 3) == 0);
      phase_end = reads_sent + $urandom_range(60, 150);
      while (reads_sent < phase_end) begin
        if (!mode) begin
          send_read(16'($urandom), 16'($urandom), 16'($urandom),
                    7'($urandom_range(0, 127)), $urandom_range(0, 9) != 0);
        end else begin
          kind = $urandom_range(0, 9);
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(BURST_MAX + 1, BURST_MAX + 8)
                                            : $urandom_range(1, BURST_MAX);
          case (kind)
            0: begin
              send_read(16'($urandom), 16'($urandom), 16'($urandom),
                        7'($urandom_range(0, 127)), $urandom_range(0, 1));
            end
            1: begin
              send_burst(len, 1'b0, 1'b1);
            end
            default: begin
              send_burst(len, $urandom_range(0, 7) == 0, 1'b0);
            end
          endcase
        end
      end
      no_stall = 1'b0;
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("fifo_burst_accel_averager_tb OK");
    else
      $display("fifo_burst_accel_averager_tb NOT OK");
    $finish;
  end

endmodule
